### hdl/hcbd_pkg.sv
// Package for the chunked body decoder: phase codes, state and result types, hex decode.
`timescale 1ns / 1ps
package hcbd_pkg;

  // Default width of the chunk size counter
  localparam int SIZE_BITS = 32;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // Parser phases
  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_EXT   = 3'd1,
    PH_DATA  = 3'd2,
    PH_SKIP  = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  // Control state carried from byte to byte (size counter travels apart)
  typedef struct packed {
    phase_t     phase;
    logic       digits_over;
    logic       saw_cr;
    logic [1:0] skip_count;
  } ctrl_t;

  // One result word
  typedef struct packed {
    logic [7:0] data_out;
    logic       is_payload;
    logic       msg_end;
    logic       size_error;
  } result_t;

  // Decode an ASCII hex digit of either case: {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
        r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
        r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
        r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
    end
  endfunction

endpackage

### hdl/hcbd_step.sv
// Next-state and result logic of the chunked body decoder for one byte.
`timescale 1ns / 1ps
module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int SizeBits = SIZE_BITS
) (
  input  ctrl_t               ctrl,
  input  logic [SizeBits-1:0] remaining,
  input  logic [7:0]          data_in,
  output ctrl_t               ctrl_next,
  output logic [SizeBits-1:0] remaining_next,
  output result_t             result
);

  logic [4:0]          hex;
  logic [SizeBits-1:0] rem_dec;
  logic [1:0]          skip_dec;
  logic                size_top;
  logic                is_cr;
  logic                is_lf;

  assign hex      = hex_decode(data_in);
  assign rem_dec  = remaining - SizeBits'(1);
  assign skip_dec = ctrl.skip_count - 2'd1;
  assign size_top = |remaining[SizeBits-1:SizeBits-4];
  assign is_cr    = (data_in == BYTE_CR);
  assign is_lf    = (data_in == BYTE_LF);

  // Advance the parser by one byte
  always_comb begin
    ctrl_next      = ctrl;
    remaining_next = remaining;
    result         = '0;
    unique case (ctrl.phase)
      PH_EXT: begin
        if (ctrl.saw_cr && is_lf) begin
          ctrl_next.digits_over = 1'b0;
          ctrl_next.saw_cr      = 1'b0;
          ctrl_next.phase       = (remaining == '0) ? PH_TRAIL : PH_DATA;
        end else begin
          ctrl_next.saw_cr = is_cr;
        end
      end
      PH_DATA: begin
        result.data_out   = data_in;
        result.is_payload = 1'b1;
        remaining_next    = rem_dec;
        if (rem_dec == '0) begin
          ctrl_next.phase      = PH_SKIP;
          ctrl_next.skip_count = 2'd2;
        end
      end
      PH_SKIP: begin
        ctrl_next.skip_count = skip_dec;
        if (skip_dec == 2'd0) begin
          ctrl_next.phase       = PH_SIZE;
          ctrl_next.digits_over = 1'b0;
          ctrl_next.saw_cr      = 1'b0;
          remaining_next        = '0;
        end
      end
      PH_TRAIL: begin
        if (ctrl.saw_cr && is_lf) begin
          result.msg_end        = 1'b1;
          ctrl_next.phase       = PH_SIZE;
          ctrl_next.digits_over = 1'b0;
          ctrl_next.saw_cr      = 1'b0;
          remaining_next        = '0;
        end else begin
          ctrl_next.saw_cr = is_cr;
        end
      end
      default: begin
        // Size digits; saturate on overflow and flag the first overflowing digit
        ctrl_next.phase = PH_SIZE;
        if (hex[4]) begin
          if (ctrl.digits_over) begin
            remaining_next = '1;
          end else if (size_top) begin
            remaining_next        = '1;
            ctrl_next.digits_over = 1'b1;
            result.size_error     = 1'b1;
          end else begin
            remaining_next = {remaining[SizeBits-5:0], hex[3:0]};
          end
        end else begin
          ctrl_next.saw_cr = is_cr;
          ctrl_next.phase  = PH_EXT;
        end
      end
    endcase
  end

endmodule

### hdl/http_chunked_body_decoder_core.sv
// Top level of the chunked body decoder: input register, parser state and output register.
// An accepted byte is held in the input register until the output register is free.
// Throughput: one byte per cycle while the output is not stalled; the output register
// and the input register let a new byte in while a finished word still waits downstream.
// The rate is set by the combinational parser update between the two registers.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to the size digits phase with a zero size counter.
`timescale 1ns / 1ps
module http_chunked_body_decoder_core
  import hcbd_pkg::*;
#(
  parameter int SizeBits = SIZE_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_in
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_out
  output logic [1:0] m_tuser,   // [0] is_payload, [1] size_error
  output logic       m_tlast    // msg_end
);

  logic                in_valid;
  logic [7:0]          in_byte;
  ctrl_t               ctrl;
  ctrl_t               ctrl_next;
  logic [SizeBits-1:0] remaining;
  logic [SizeBits-1:0] remaining_next;
  result_t             result;
  logic                out_free;
  logic                advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Hold the incoming word until the parser takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  hcbd_step #(
    .SizeBits(SizeBits)
  ) u_step (
    .ctrl          (ctrl),
    .remaining     (remaining),
    .data_in       (in_byte),
    .ctrl_next     (ctrl_next),
    .remaining_next(remaining_next),
    .result        (result)
  );

  // Advance parser state once per word moved to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= '{phase: PH_SIZE, digits_over: 1'b0, saw_cr: 1'b0, skip_count: 2'd0};
      remaining <= '0;
    end else if (advance) begin
      ctrl      <= ctrl_next;
      remaining <= remaining_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance) begin
      m_tdata <= result.data_out;
      m_tuser <= {result.size_error, result.is_payload};
      m_tlast <= result.msg_end;
    end
  end

endmodule

### tb/http_chunked_body_decoder_core_test.sv
// Testbench for the chunked body decoder: random and directed byte streams checked against a predictor.
`timescale 1ns / 1ps
module http_chunked_body_decoder_core_test;
  import hcbd_pkg::*;

  localparam int TX = 0;
  localparam int RX = 1;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BYTES = 1300;
  localparam logic [SIZE_BITS-1:0] SIZE_FULL = '1;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  // Raw body bytes still to send, and decoded words still to arrive
  logic [7:0] body_q [$];
  result_t    decoded_q [$];

  // Predictor state
  phase_t               ph;
  logic [SIZE_BITS-1:0] left;
  logic                 over;
  logic                 cr_seen;
  logic [1:0]           skip_left;

  int sent_cnt = 0;
  int hold_at = -1;
  int tx_gap = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int fail_cnt = 0;
  int calm [2] = '{0, 0};

  http_chunked_body_decoder_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // {is_hex, value} of an ASCII byte
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
    if (b >= 8'h61 && b <= 8'h66) return {1'b1, b[3:0] + 4'd9};
    if (b >= 8'h41 && b <= 8'h46) return {1'b1, b[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int pick_gap(input int side);
    int r;
    if (calm[side] > 0) begin
      calm[side]--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 2) begin
      calm[side] = $urandom_range(120, 30);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Advance the predictor by one body byte and return the word it yields
  function automatic result_t decode_byte(input logic [7:0] b);
    result_t    w;
    logic [4:0] hx;
    w = '0;
    case (ph)
      PH_EXT: begin
        if (cr_seen && b == BYTE_LF) begin
          over = 1'b0;
          cr_seen = 1'b0;
          ph = (left == '0) ? PH_TRAIL : PH_DATA;
        end else begin
          cr_seen = (b == BYTE_CR);
        end
      end
      PH_DATA: begin
        w.data_out = b;
        w.is_payload = 1'b1;
        left = left - SIZE_BITS'(1);
        if (left == '0) begin
          ph = PH_SKIP;
          skip_left = 2'd2;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 2'd1;
        if (skip_left == 2'd0) begin
          ph = PH_SIZE;
          left = '0;
          over = 1'b0;
          cr_seen = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (cr_seen && b == BYTE_LF) begin
          w.msg_end = 1'b1;
          ph = PH_SIZE;
          left = '0;
          over = 1'b0;
          cr_seen = 1'b0;
        end else begin
          cr_seen = (b == BYTE_CR);
        end
      end
      default: begin
        hx = hex_nibble(b);
        ph = PH_SIZE;
        if (hx[4]) begin
          if (over) begin
            left = SIZE_FULL;
          end else if (left > (SIZE_FULL >> 4)) begin
            // saturate and flag only the digit that overflows
            left = SIZE_FULL;
            over = 1'b1;
            w.size_error = 1'b1;
          end else begin
            left = {left[SIZE_BITS-5:0], hx[3:0]};
          end
        end else begin
          cr_seen = (b == BYTE_CR);
          ph = PH_EXT;
        end
      end
    endcase
    return w;
  endfunction

  task automatic put(input logic [7:0] b);
    body_q.push_back(b);
  endtask

  task automatic put_crlf();
    put(BYTE_CR);
    put(BYTE_LF);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endtask

  // Free-form line content; a CR is always followed by a non-LF byte
  task automatic put_junk(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255, 0));
      put(b);
      if (b == BYTE_CR) put(8'h7A);
    end
  endtask

  // Chunk header: hex size in mixed case, then a line end or an extension
  task automatic add_header(input int unsigned size, input bit no_digits);
    logic [7:0]  digs [$];
    logic [7:0]  t;
    logic [4:0]  hx;
    int unsigned v;
    logic [3:0]  nib;
    v = size;
    if (!no_digits) begin
      do begin
        nib = v[3:0];
        v = v >> 4;
        if (nib < 4'd10) digs.push_front(8'h30 + {4'h0, nib});
        else digs.push_front(($urandom_range(1, 0) ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10);
      end while (v != 0);
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(3, 1)) digs.push_front(8'h30);
      foreach (digs[i]) put(digs[i]);
    end
    if (!no_digits && $urandom_range(9, 0) < 6) begin
      put_crlf();
    end else begin
      do begin
        t = 8'($urandom_range(255, 0));
        hx = hex_nibble(t);
      end while (hx[4]);
      put(t);
      if (t == BYTE_CR) begin
        put(BYTE_LF);
      end else begin
        put_junk($urandom_range(6, 0));
        put_crlf();
      end
    end
  endtask

  // Message of random chunks and content, with occasional junk and non-CRLF chunk ends
  task automatic add_message();
    int unsigned size;
    int          r;
    repeat ($urandom_range(4, 0)) begin
      r = $urandom_range(99, 0);
      if (r < 85) size = $urandom_range(16, 1);
      else if (r < 97) size = $urandom_range(64, 17);
      else size = $urandom_range(300, 65);
      add_header(size, 1'b0);
      repeat (size) put(8'($urandom_range(255, 0)));
      if ($urandom_range(5, 0) == 0) begin
        put(8'($urandom_range(255, 0)));
        put(8'($urandom_range(255, 0)));
      end else begin
        put_crlf();
      end
    end
    add_header(0, $urandom_range(7, 0) == 0);
    if ($urandom_range(3, 0) == 0) put_junk($urandom_range(8, 1));
    put_crlf();
  endtask

  // Driver: present body bytes, predict each accepted byte
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      ph = PH_SIZE;
      left = '0;
      over = 1'b0;
      cr_seen = 1'b0;
      skip_left = 2'd0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        decoded_q.push_back(decode_byte(s_tdata));
        sent_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (body_q.size() != 0 &&
                     !(sent_cnt == hold_at && decoded_q.size() != 0)) begin
          s_tdata <= body_q.pop_front();
          s_tvalid <= 1'b1;
          tx_gap = pick_gap(TX);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each decoded word against the oldest prediction, stall at random
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          $error("decoded word with nothing expected: data_out %0h", m_tdata);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.data_out) begin
            $error("data_out: expected %0h, got %0h", want.data_out, m_tdata);
            fail_cnt++;
          end
          if (m_tuser[0] !== want.is_payload) begin
            $error("is_payload: expected %0b, got %0b", want.is_payload, m_tuser[0]);
            fail_cnt++;
          end
          if (m_tlast !== want.msg_end) begin
            $error("msg_end: expected %0b, got %0b", want.msg_end, m_tlast);
            fail_cnt++;
          end
          if (m_tuser[1] !== want.size_error) begin
            $error("size_error: expected %0b, got %0b", want.size_error, m_tuser[1]);
            fail_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(3, 0) == 0) begin
        stall_left = pick_gap(RX);
        m_tready <= (stall_left == 0);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("[http_chunked_body_decoder_core] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    // CR right after digits, payload extremes
    put_str("2");
    put_crlf();
    put(8'h00);
    put(8'hFF);
    put_crlf();
    // leading zero, lone LF, CR CR LF line end, unchecked bytes after data
    put_str("01");
    put(BYTE_LF);
    put(BYTE_CR);
    put(BYTE_CR);
    put(BYTE_LF);
    put(8'h5A);
    put(BYTE_CR);
    put(8'h41);
    // zero chunk, trailer line ends the message at its first CR LF
    put_str("0");
    put_crlf();
    put_str("T");
    put_crlf();
    // header with no digits ends the message as well
    put_crlf();
    put_crlf();

    // sender waits here until every word so far has come back
    hold_at = body_q.size();

    while (body_q.size() < RANDOM_BYTES) add_message();

    // size overflow last: the saturated chunk never ends
    put_str("FFFFFFFFf7;");
    put_crlf();
    repeat (4) put(8'($urandom_range(255, 0)));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (body_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("[http_chunked_body_decoder_core] OK");
    end else begin
      $display("[http_chunked_body_decoder_core] ERROR");
    end
    $finish;
  end

endmodule
